[src/isc_pkg.sv]
// ---------------------------------------------------------------------------
// isc_pkg
// Shared constants and types for the item support counter.
// ---------------------------------------------------------------------------
`default_nettype none

package isc_pkg;

   // Counter store geometry.
   localparam int ITEM_IDS   = 4096;
   localparam int COUNT_BITS = 24;
   localparam int ADDR_BITS  = (ITEM_IDS > 1) ? $clog2(ITEM_IDS) : 1;

   // Field widths of the ports.
   localparam int ID_BITS     = 12;
   localparam int FIELD_BITS  = 24;
   localparam logic [FIELD_BITS-1:0] FIELD_MAX = {FIELD_BITS{1'b1}};

   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef enum logic [1:0] {
      OP_COUNT    = 2'd0,
      OP_QUERY    = 2'd1,
      OP_CLEAR    = 2'd2,
      OP_RESERVED = 2'd3
   } opcode_type;

endpackage

`default_nettype wire

[src/item_support_counter_unit.sv]
// ---------------------------------------------------------------------------
// item_support_counter_unit
// Per-item saturating occurrence counters with support threshold check.
// ---------------------------------------------------------------------------
// A user reads this first: after reset the block sweeps its counter store to
// zero, one entry per cycle, so busy stays high until all ITEM_IDS (4096)
// entries are cleared, and no command is taken during that time; threshold
// writes are taken at any time. Afterwards busy stays low and a command may
// be issued on every cycle. Each command (count, query, clear; the unused
// opcode acts as a query) produces exactly one response word, registered
// through stage 1 and the response registers, shown for one cycle with
// rsp_valid high. The receiver cannot stall: the response must be captured
// in that cycle. Throughput is one command per cycle, set by the single
// read-modify-write through the counter memory; a write forwarded from the
// previous command covers back-to-back hits on the same item.
// ---------------------------------------------------------------------------
`default_nettype none

module item_support_counter_unit
   import isc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // command channel
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [ID_BITS-1:0]    req_item_id,
   // response channel
   output logic                       rsp_valid,
   output logic [FIELD_BITS-1:0]      rsp_item_count,
   output logic                       rsp_is_large,
   // threshold register write channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [FIELD_BITS-1:0] csr_data
);

   localparam addr_type LAST_ADDR = ADDR_BITS'(ITEM_IDS - 1);

   // Clearing sweep after reset.
   logic      clearing_ff, clearing_in;
   addr_type  clr_ptr_ff, clr_ptr_in;

   // Threshold register.
   logic [FIELD_BITS-1:0] threshold_ff, threshold_in;

   // Stage 1: command waiting for its read data.
   logic       s1_valid_ff, s1_valid_in;
   opcode_type s1_op_ff;
   addr_type   s1_addr_ff;
   logic       s1_in_range_ff;

   // Last word written, forwarded over the read-first memory.
   logic      fw_valid_ff, fw_valid_in;
   addr_type  fw_addr_ff;
   count_type fw_data_ff;

   // Response registers.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                  rsp_large_ff, rsp_large_in;

   logic      accept;
   logic      req_in_range;
   count_type rd_data;
   count_type old_count;
   count_type new_count;
   count_type result_count;
   logic      op_write;
   logic      wr_en;
   addr_type  wr_addr;
   count_type wr_data;

   assign busy      = clearing_ff;
   assign accept    = start && !clearing_ff;
   assign csr_ready = 1'b1;

   assign req_in_range = (32'(req_item_id) < 32'(ITEM_IDS));

   // Pick the freshest copy of the entry.
   always_comb begin
      if (fw_valid_ff && (fw_addr_ff == s1_addr_ff)) begin
         old_count = fw_data_ff;
      end else begin
         old_count = rd_data;
      end
   end

   // Modify: saturate on count, zero on clear, hold otherwise.
   always_comb begin
      op_write = 1'b0;
      case (s1_op_ff)
         OP_COUNT: begin
            op_write  = 1'b1;
            new_count = (old_count != {COUNT_BITS{1'b1}}) ?
                        count_type'(old_count + 1'b1) : old_count;
         end
         OP_CLEAR: begin
            op_write  = 1'b1;
            new_count = '0;
         end
         default: begin
            new_count = old_count;
         end
      endcase
   end

   assign result_count = s1_in_range_ff ? new_count : '0;

   // Write port: sweep during clearing, else write back the modified word.
   always_comb begin
      if (clearing_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_ptr_ff;
         wr_data = '0;
      end else begin
         wr_en   = s1_valid_ff && s1_in_range_ff && op_write;
         wr_addr = s1_addr_ff;
         wr_data = new_count;
      end
   end

   always_comb begin
      clearing_in  = clearing_ff;
      clr_ptr_in   = clr_ptr_ff;
      if (clearing_ff) begin
         clr_ptr_in = clr_ptr_ff + 1'b1;
         if (clr_ptr_ff == LAST_ADDR) begin
            clearing_in = 1'b0;
         end
      end
      threshold_in = (csr_valid && csr_ready) ? csr_data : threshold_ff;
      s1_valid_in  = accept;
      fw_valid_in  = wr_en ? 1'b1 : fw_valid_ff;
      rsp_valid_in = s1_valid_ff;
      // Clamp the reported count to the field; compare the full count.
      rsp_count_in = (32'(result_count) > 32'(FIELD_MAX)) ?
                     FIELD_MAX : FIELD_BITS'(result_count);
      rsp_large_in = (32'(result_count) >= 32'(threshold_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_ptr_ff   <= '0;
         threshold_ff <= FIELD_BITS'(1);
         s1_valid_ff  <= 1'b0;
         fw_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_ptr_ff   <= clr_ptr_in;
         threshold_ff <= threshold_in;
         s1_valid_ff  <= s1_valid_in;
         fw_valid_ff  <= fw_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff       <= opcode_type'(req_opcode);
         s1_addr_ff     <= ADDR_BITS'(req_item_id);
         s1_in_range_ff <= req_in_range;
      end
      if (wr_en) begin
         fw_addr_ff <= wr_addr;
         fw_data_ff <= wr_data;
      end
      rsp_count_ff <= rsp_count_in;
      rsp_large_ff <= rsp_large_in;
   end

   isc_count_ram u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ADDR_BITS'(req_item_id)),
      .rd_data (rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_item_count = rsp_count_ff;
   assign rsp_is_large   = rsp_large_ff;

endmodule

`default_nettype wire

[src/isc_count_ram.sv]
// ---------------------------------------------------------------------------
// isc_count_ram
// Single-port-write, single-port-read counter store, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module isc_count_ram
   import isc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      wr_en,
   input  wire addr_type  wr_addr,
   input  wire count_type wr_data,
   input  wire addr_type  rd_addr,
   output logic           [COUNT_BITS-1:0] rd_data
);

   count_type mem [ITEM_IDS];
   count_type rd_data_ff;

   // Read-first: a read at the address being written returns the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[tb/item_support_counter_unit_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// item_support_counter_unit_test
// Self-checking regression for the item support counter. Commands go in over
// the start/busy channel and are scored against a cycle-free model of the
// per-item occurrence counters and the support threshold. Every response
// word is matched in order against the oldest predicted word. Directed
// checks cover the reset state, every opcode and the threshold extremes.
// Random traffic then runs over several threshold settings and idle mixes.
// ---------------------------------------------------------------------------
module item_support_counter_unit_test;
   import isc_pkg::*;

   // The reset sweep clears ITEM_IDS entries, and each of about 800 commands
   // takes a short random gap at most. This limit is far above that.
   localparam int CYCLE_LIMIT  = 200000;
   // A response is registered through stage 1 and the response registers.
   // Keep waiting after the drain to catch any stray word.
   localparam int DRAIN_CYCLES = 8;

   // One response word as the block reports it.
   typedef struct packed {
      logic [FIELD_BITS-1:0] item_count;
      logic                  is_large;
   } support_word_type;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  start          = 1'b0;
   logic                  busy;
   logic [1:0]            req_opcode     = OP_QUERY;
   logic [ID_BITS-1:0]    req_item_id    = '0;
   logic                  rsp_valid;
   logic [FIELD_BITS-1:0] rsp_item_count;
   logic                  rsp_is_large;
   logic                  csr_valid      = 1'b0;
   logic                  csr_ready;
   logic [FIELD_BITS-1:0] csr_data       = '0;

   // Model state: one counter per item id, plus the threshold the block holds.
   count_type             tally [ITEM_IDS];
   logic [FIELD_BITS-1:0] threshold_copy;

   // Predicted response words, oldest first.
   support_word_type      pending_words [$];

   int                    error_count = 0;
   int                    cycle_count = 0;
   // Share, in percent, of cycles in which the sender stays idle.
   int                    idle_pct    = 0;

   item_support_counter_unit dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_item_id    (req_item_id),
      .rsp_valid      (rsp_valid),
      .rsp_item_count (rsp_item_count),
      .rsp_is_large   (rsp_is_large),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   always #5 clock = ~clock;

   // Apply one command to the model counters and return the word it should
   // produce. The reserved opcode reads like a query. An id past the store
   // reads as zero and touches nothing.
   function automatic support_word_type tally_item(input opcode_type op,
                                                   input logic [ID_BITS-1:0] id);
      logic [31:0]      level;
      support_word_type word;
      level = '0;
      if (int'(id) < ITEM_IDS) begin
         case (op)
            OP_COUNT: if (tally[id] != '1) tally[id] = tally[id] + 1'b1;
            OP_CLEAR: tally[id] = '0;
            default: ;
         endcase
         level = 32'(tally[id]);
      end
      // Clip the reported count to the port width. The compare below
      // still uses the full count.
      word.item_count = (level > 32'(FIELD_MAX)) ? FIELD_MAX : level[FIELD_BITS-1:0];
      word.is_large   = (level >= 32'(threshold_copy));
      return word;
   endfunction

   // Present one command and hold it until the block takes it. Keep start
   // high on return so the next command follows back to back. Idle cycles
   // are drawn one at a time, so idle_pct is the share of idle cycles.
   task automatic send_item(input opcode_type op, input logic [ID_BITS-1:0] id);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_opcode  <= op;
      req_item_id <= id;
      // busy read here is its value before this edge, so it shows whether
      // the command was taken.
      do @(posedge clock); while (busy);
      pending_words.push_back(tally_item(op, id));
   endtask

   // Drop start and wait until every predicted word has come back.
   task automatic drain_words();
      start <= 1'b0;
      do @(posedge clock); while (pending_words.size() != 0);
   endtask

   // Write the threshold with no command in flight, so the next command sees
   // the new value.
   task automatic write_threshold(input logic [FIELD_BITS-1:0] value);
      drain_words();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid      <= 1'b0;
      threshold_copy = value;
      @(posedge clock);
   endtask

   // After the sweep every counter reads zero. The reset threshold of one
   // makes a single occurrence large. Use ids at both ends and
   // alternating bit patterns.
   task automatic test_reset_state();
      send_item(OP_QUERY, '0);
      send_item(OP_QUERY, '1);
      send_item(OP_QUERY, 12'hAAA);
      send_item(OP_QUERY, 12'h555);
      send_item(OP_COUNT, '0);
      send_item(OP_COUNT, '1);
      drain_words();
   endtask

   // Send each opcode to one item. The back-to-back counts exercise the
   // forwarding path. The reserved opcode must leave the count alone.
   task automatic test_opcodes();
      send_item(OP_COUNT, 12'h123);
      send_item(OP_COUNT, 12'h123);
      send_item(OP_COUNT, 12'h123);
      send_item(OP_RESERVED, 12'h123);
      send_item(OP_QUERY, 12'h123);
      send_item(OP_CLEAR, 12'h123);
      send_item(OP_QUERY, 12'h123);
      send_item(OP_COUNT, 12'h123);
      drain_words();
   endtask

   // With threshold zero even an empty or cleared entry is large. With the
   // maximum threshold nothing reachable is large. Counter saturation needs
   // 2^24 - 1 counts on one item and stays out of reach in this run.
   task automatic test_threshold_extremes();
      write_threshold('0);
      send_item(OP_QUERY, 12'h7FF);
      send_item(OP_CLEAR, 12'h123);
      write_threshold(FIELD_MAX);
      send_item(OP_COUNT, 12'h123);
      send_item(OP_QUERY, '1);
      write_threshold(24'd2);
      send_item(OP_COUNT, 12'h123);
      send_item(OP_QUERY, 12'h123);
      drain_words();
   endtask

   // Run random traffic under one threshold and one sender idle rate. Most
   // commands hit a small set of hot items, so counts climb past the
   // threshold between clears. The rest spread over the whole id range.
   task automatic test_random_traffic(input int                    words,
                                      input int                    pct,
                                      input logic [FIELD_BITS-1:0] level);
      logic [ID_BITS-1:0] hot [8];
      logic [ID_BITS-1:0] id;
      opcode_type         op;
      int                 roll;
      write_threshold(level);
      idle_pct = pct;
      foreach (hot[k]) hot[k] = ID_BITS'($urandom);
      for (int n = 0; n < words; n++) begin
         roll = $urandom_range(99);
         if (roll < 60) op = OP_COUNT;
         else if (roll < 82) op = OP_QUERY;
         else if (roll < 93) op = OP_CLEAR;
         else op = OP_RESERVED;
         id = ($urandom_range(3) != 0) ? hot[$urandom_range(7)] : ID_BITS'($urandom);
         send_item(op, id);
      end
      idle_pct = 0;
      // Hold the sender until every word is back.
      drain_words();
   endtask

   // Take each response word in the cycle it is shown and compare it with
   // the oldest prediction. The block cannot hold a word, so check every
   // strobe.
   always @(posedge clock) begin
      support_word_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_words.size() == 0) begin
            $error("unexpected response word: item_count %0d is_large %0b",
                   rsp_item_count, rsp_is_large);
            error_count++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_item_count !== want.item_count) begin
               $error("item_count: expected %0d, got %0d", want.item_count, rsp_item_count);
               error_count++;
            end
            if (rsp_is_large !== want.is_large) begin
               $error("is_large: expected %0b, got %0b", want.is_large, rsp_is_large);
               error_count++;
            end
         end
      end
   end

   // End a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("item_support_counter_unit regression: fail");
         $finish;
      end
   end

   initial begin
      foreach (tally[k]) tally[k] = '0;
      threshold_copy = 24'd1;
      // Hold reset first. The block then sweeps its store while busy is high,
      // and send_item waits that out.
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_opcodes();
      test_threshold_extremes();

      // Run the random phases: back to back, sender idle 46 of 100, then
      // the mixed rate of 21 of 100. The last phase may draw threshold
      // zero.
      test_random_traffic(250, 0, 24'd3);
      test_random_traffic(250, 46, FIELD_BITS'($urandom_range(1, 10)));
      test_random_traffic(250, 21, FIELD_BITS'($urandom_range(0, 6)));

      drain_words();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("item_support_counter_unit regression: pass");
      end else begin
         $display("item_support_counter_unit regression: fail");
      end
      $finish;
   end

endmodule
